// ----- rtl/assert_macros.svh -----
// Assertion helpers; the enclosing module must provide clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an expression never holds outside reset
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

// ----- rtl/mts_pkg.sv -----
package mts_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int CAP_W          = 5;
  localparam int DEFAULT_CAP    = 10;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEFAULT_CAP);

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic load;
    logic emit;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pop_ok;
  } dp_stat_t;

endpackage

// ----- rtl/mts_ctrl.sv -----
`include "assert_macros.svh"

module mts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  mts_pkg::dp_stat_t stat,
  output mts_pkg::ctl_cmd_t cmd
);
  import mts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_LOAD = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        // a successful pop must fetch the entries below the old top
        state_next = stat.pop_ok ? S_LOAD : S_RESP;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_CLK(a_accept_to_exec, (in_valid && !in_stall) |=> (state == S_EXEC),
              "accepted request did not start execution")
  `ASSERT_CLK(a_load_to_resp, (state == S_LOAD) |=> (state == S_RESP),
              "load step did not advance to response")
  `ASSERT_CLK(a_resp_fills_slot, (state == S_RESP && slot_free) |=> out_valid,
              "response not presented when output slot was free")

endmodule

// ----- rtl/mts_dpath.sv -----
`include "assert_macros.svh"

module mts_dpath #(
  parameter int DEPTH      = mts_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mts_pkg::ctl_cmd_t                 cmd,
  output mts_pkg::dp_stat_t                 stat,
  input  logic                              cfg_we,
  input  logic [mts_pkg::CAP_W-1:0]         cfg_data,
  input  logic                              action,
  input  logic signed [DATA_WIDTH-1:0]      value,
  output logic [1:0]                        status,
  output logic signed [DATA_WIDTH-1:0]      popped_value,
  output logic signed [DATA_WIDTH-1:0]      top_value,
  output logic signed [DATA_WIDTH-1:0]      min_value,
  output logic [$clog2(DEPTH+1)-1:0]        entry_count
);
  import mts_pkg::*;

  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = $clog2(DEPTH + 1);
  localparam int XW       = (CW > CAP_W) ? CW : CAP_W;
  localparam int FALLBACK = (DEFAULT_CAP < DEPTH) ? DEFAULT_CAP : DEPTH;

  logic signed [DATA_WIDTH-1:0] value_mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] min_mem   [DEPTH];

  logic [CAP_W-1:0]             capacity;
  logic [CW-1:0]                cnt;
  logic [CW-1:0]                mcnt;
  logic                         item_action;
  logic signed [DATA_WIDTH-1:0] item_value;
  logic signed [DATA_WIDTH-1:0] top_reg;
  logic signed [DATA_WIDTH-1:0] min_reg;
  logic signed [DATA_WIDTH-1:0] popped_reg;
  logic signed [DATA_WIDTH-1:0] rd_value;
  logic signed [DATA_WIDTH-1:0] rd_min;
  status_t                      status_reg;
  logic                         drop_reg;

  logic [XW-1:0] cap_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] eff_cap;
  logic          full;
  logic          empty;
  logic          take;
  logic          drop;
  logic [CW-1:0] mcnt_base;
  logic [CW-1:0] rd_addr_v;
  logic [CW-1:0] rd_addr_m;

  always_comb begin
    cap_x     = XW'(capacity);
    cnt_x     = XW'(cnt);
    // out-of-range capacity falls back to the default, limited to the depth
    eff_cap   = (cap_x != '0 && cap_x <= XW'(DEPTH)) ? cap_x : XW'(FALLBACK);
    full      = (cnt_x >= eff_cap);
    empty     = (cnt == '0);
    take      = empty || (item_value <= min_reg);
    drop      = (min_reg == top_reg);
    mcnt_base = empty ? '0 : mcnt;
    rd_addr_v = cnt - CW'(2);
    rd_addr_m = mcnt - CW'(2);
  end

  assign stat.pop_ok = (item_action == ACT_POP) && !empty;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      cnt      <= '0;
      mcnt     <= '0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (cmd.exec) begin
        if (item_action == ACT_PUSH) begin
          if (!full) begin
            cnt  <= cnt + CW'(1);
            mcnt <= take ? mcnt_base + CW'(1) : mcnt_base;
          end
        end else if (!empty) begin
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            mcnt <= '0;
          end else if (drop) begin
            mcnt <= mcnt - CW'(1);
          end
        end
      end
    end
  end

  // stores, cached top and minimum, result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_action <= action;
      item_value  <= value;
    end
    // prefetch the entries that become the top after a pop
    rd_value <= value_mem[rd_addr_v[AW-1:0]];
    rd_min   <= min_mem[rd_addr_m[AW-1:0]];
    if (cmd.exec) begin
      popped_reg <= '0;
      drop_reg   <= 1'b0;
      if (item_action == ACT_PUSH) begin
        if (full) begin
          status_reg <= ST_FULL;
        end else begin
          status_reg                <= ST_DONE;
          value_mem[cnt[AW-1:0]]    <= item_value;
          top_reg                   <= item_value;
          if (take) begin
            min_mem[mcnt_base[AW-1:0]] <= item_value;
            min_reg                    <= item_value;
          end
        end
      end else begin
        if (empty) begin
          status_reg <= ST_EMPTY;
        end else begin
          status_reg <= ST_DONE;
          popped_reg <= top_reg;
          drop_reg   <= drop;
        end
      end
    end
    if (cmd.load) begin
      top_reg <= rd_value;
      if (drop_reg) begin
        min_reg <= rd_min;
      end
    end
    if (cmd.emit) begin
      status       <= status_reg;
      popped_value <= popped_reg;
      top_value    <= (cnt != '0) ? top_reg : '1;
      min_value    <= (cnt != '0 && mcnt != '0) ? min_reg : '0;
      entry_count  <= cnt;
    end
  end

  `ASSERT_CLK(a_mcnt_le_cnt, mcnt <= cnt, "minimum stack deeper than value stack")
  `ASSERT_NEVER(a_min_missing, (cnt != '0) && (mcnt == '0),
                "non-empty stack with no minimum entry")
  `ASSERT_CLK(a_cnt_le_depth, cnt <= CW'(DEPTH), "entry count beyond depth")

endmodule

// ----- rtl/min_tracking_stack.sv -----
// A push or refused request runs through the execute and response steps; a successful pop
// adds a load step between them, taking the registered store read as the new top.
// Requests are not taken while one is in flight (in_stall); the next request is taken
// while the previous result waits at the output.
// Reset (rst, synchronous): stack and minimum stack empty, capacity 10, no result
// pending; stores need no clearing pass and requests are taken right after reset.
module min_tracking_stack #(
  parameter int DEPTH      = mts_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic signed [DATA_WIDTH-1:0]      value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic signed [DATA_WIDTH-1:0]      popped_value,
  output logic signed [DATA_WIDTH-1:0]      top_value,
  output logic signed [DATA_WIDTH-1:0]      min_value,
  output logic [$clog2(DEPTH+1)-1:0]        entry_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mts_pkg::CAP_W-1:0]         cfg_data
);
  import mts_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mts_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .action       (action),
    .value        (value),
    .status       (status),
    .popped_value (popped_value),
    .top_value    (top_value),
    .min_value    (min_value),
    .entry_count  (entry_count)
  );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import mts_pkg::*;

  localparam int DEPTH = 16;
  localparam int DW = 32;
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    status_t status;
    logic signed [DW-1:0] popped;
    logic signed [DW-1:0] top;
    logic signed [DW-1:0] minv;
    logic [4:0] count;
  } stack_result_t;

  class stack_tracker;
    stack_result_t pending_results[$];
    logic signed [DW-1:0] value_stk[DEPTH];
    logic signed [DW-1:0] min_stk[DEPTH];
    int fill;
    int min_fill;
    logic [CAP_W-1:0] capacity;
    int mismatches;

    function new();
      fill = 0;
      min_fill = 0;
      capacity = CAP_RESET;
      mismatches = 0;
    endfunction

    // out-of-range settings fall back to the default
    function int cap_limit();
      if (capacity >= 1 && capacity <= DEPTH) return capacity;
      return (DEFAULT_CAP < DEPTH) ? DEFAULT_CAP : DEPTH;
    endfunction

    function void note_request(logic act, logic signed [DW-1:0] val);
      stack_result_t r;
      bit take;
      r.status = ST_DONE;
      r.popped = '0;
      if (act == ACT_PUSH) begin
        if (fill >= cap_limit()) begin
          r.status = ST_FULL;
        end else begin
          if (min_fill == 0 || fill == 0) take = 1'b1;
          else take = (val <= min_stk[min_fill-1]);
          if (fill == 0) min_fill = 0;
          if (take && min_fill < DEPTH) begin
            min_stk[min_fill] = val;
            min_fill++;
          end
          value_stk[fill] = val;
          fill++;
        end
      end else begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = value_stk[fill-1];
          // drop the minimum entry only when this copy is the one recorded
          if (min_fill > 0 && min_stk[min_fill-1] == r.popped) min_fill--;
          fill--;
          if (fill == 0) min_fill = 0;
        end
      end
      r.top = (fill > 0) ? value_stk[fill-1] : -1;
      r.minv = (fill > 0 && min_fill > 0) ? min_stk[min_fill-1] : '0;
      r.count = fill[4:0];
      pending_results = {pending_results, r};
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [1:0] st, logic signed [DW-1:0] popped,
                      logic signed [DW-1:0] top, logic signed [DW-1:0] minv,
                      logic [4:0] count);
      stack_result_t e;
      if (pending_results.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      e = pending_results.pop_front();
      if (st !== e.status)
        report($sformatf("status got %0d expected %0d", st, e.status));
      if (popped !== e.popped)
        report($sformatf("popped_value got %0d expected %0d", popped, e.popped));
      if (top !== e.top)
        report($sformatf("top_value got %0d expected %0d", top, e.top));
      if (minv !== e.minv)
        report($sformatf("min_value got %0d expected %0d", minv, e.minv));
      if (count !== e.count)
        report($sformatf("entry_count got %0d expected %0d", count, e.count));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = ACT_PUSH;
  logic signed [DW-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic signed [DW-1:0] popped_value;
  logic signed [DW-1:0] top_value;
  logic signed [DW-1:0] min_value;
  logic [4:0] entry_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  stack_tracker model = new();
  bit calm = 1'b0;
  int idle_cycles = 0;

  min_tracking_stack #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DW)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .popped_value(popped_value),
    .top_value(top_value),
    .min_value(min_value),
    .entry_count(entry_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check, throttle, and watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        model.check_result(status, popped_value, top_value, min_value, entry_count);
      out_stall <= !calm && ($urandom_range(0, 99) < 21);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task send_request(input logic req_act, input logic signed [DW-1:0] req_val);
    if (!calm && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= req_act;
    value <= req_val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model.note_request(req_act, req_val);
  endtask

  // hold the sender until every outstanding result is back, then let the block settle
  task hold_until_empty();
    in_valid <= 1'b0;
    while (model.pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model.capacity = cap;
  endtask

  function logic signed [DW-1:0] next_value();
    logic signed [DW-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7fffffff;
          1: v = 32'sh80000000;
          2: v = '0;
          default: v = -1;
        endcase
      end
      1, 2: v = $urandom;
      3: begin
        // repeat the current minimum to exercise duplicate tracking
        if (model.min_fill > 0 && model.fill > 0) v = model.min_stk[model.min_fill-1];
        else v = $urandom;
      end
      default: v = $signed($urandom_range(0, 16)) - 8;
    endcase
    return v;
  endfunction

  // bursts of fills, drains and mixed traffic with random content
  task run_phase(input int n);
    int done;
    int kind;
    int len;
    int i;
    done = 0;
    while (done < n) begin
      kind = $urandom_range(0, 3);
      if (kind == 0) len = model.cap_limit() - model.fill + $urandom_range(0, 2);
      else if (kind == 1) len = model.fill + $urandom_range(0, 2);
      else len = $urandom_range(4, 16);
      if (len < 1) len = 1;
      for (i = 0; i < len && done < n; i++) begin
        if (kind == 0) send_request(ACT_PUSH, next_value());
        else if (kind == 1) send_request(ACT_POP, next_value());
        else if ($urandom_range(0, 99) < 55) send_request(ACT_PUSH, next_value());
        else send_request(ACT_POP, next_value());
        done++;
      end
    end
  endtask

  logic [CAP_W-1:0] cap_plan[10] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17,
                                      5'd16, 5'd3, 5'd8, 5'd12, 5'd2};

  initial begin
    int i;
    int p;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, duplicate minima, pop empty, push full
    send_request(ACT_POP, 32'sh12345678);
    send_request(ACT_PUSH, 32'sh7fffffff);
    send_request(ACT_PUSH, 32'sh80000000);
    send_request(ACT_PUSH, 32'sh80000000);
    send_request(ACT_PUSH, '0);
    send_request(ACT_PUSH, -1);
    for (i = 0; i < 6; i++) send_request(ACT_POP, '1);
    for (i = 0; i < 11; i++) send_request(ACT_PUSH, $signed(i % 3) - 1);
    hold_until_empty();

    for (p = 0; p < 10; p++) begin
      write_capacity(cap_plan[p]);
      calm = (p == 4);
      run_phase(35);
      if (p == 2) hold_until_empty();
      run_phase(35);
      // leave the stack full before the capacity drops below the fill
      if (cap_plan[p] == 5'd16) begin
        while (model.fill < DEPTH) send_request(ACT_PUSH, next_value());
        send_request(ACT_PUSH, next_value());
      end
      hold_until_empty();
    end
    calm = 1'b0;

    if (model.mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mts_pkg.sv
rtl/mts_ctrl.sv
rtl/mts_dpath.sv
rtl/min_tracking_stack.sv
tb/sv/testbench.sv
